// ----- src/itm_pkg.sv -----
// Shared types and constants for the idle-framed tag matcher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package itm_pkg;

	localparam int TAG_ENTRIES = 16;
	localparam int TAG_BYTES   = 16;
	localparam int FRAME_MAX   = 64;
	localparam int TAG_OFFSET  = 11;

	localparam int REPLY_LEN = 12;
	localparam int MATCH_MIN = TAG_OFFSET + TAG_BYTES;

	localparam int ENTRY_W = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
	localparam int BYTE_W  = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
	localparam int ISSUE_W = ENTRY_W + 1;
	localparam int ID_W    = $clog2(TAG_ENTRIES + 1);
	localparam int LEN_W   = $clog2(FRAME_MAX + 1);
	localparam int MASK_W  = 17;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_LOAD = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_IDLE_LIMIT  = 2'd0,
		CFG_LED_HOLD    = 2'd1,
		CFG_IGNORE_MASK = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_TICK,
		CMD_LOAD,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] byte_value;
		logic [3:0] entry_index;
		logic [3:0] byte_index;
	} in_item_t;

	typedef struct packed {
		logic       frame_done;
		logic       reply_request;
		logic [4:0] match_id;
		logic       led_on;
		logic       overflow;
	} out_item_t;

	typedef struct packed {
		logic [15:0]       idle_limit;
		logic [15:0]       led_hold;
		logic [MASK_W-1:0] ignore_mask;
	} cfg_regs_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         value;
		logic [ENTRY_W-1:0] entry;
		logic [BYTE_W-1:0]  bsel;
	} cmd_t;

	typedef logic [TAG_BYTES-1:0][7:0] tag_row_t;

	typedef struct packed {
		logic               en;
		logic [ENTRY_W-1:0] entry;
		logic [BYTE_W-1:0]  bsel;
		logic [7:0]         value;
	} tag_wr_t;

	typedef struct packed {
		logic               done;
		logic               hit;
		logic [ENTRY_W-1:0] idx;
	} match_rsp_t;

endpackage

// ----- src/idle_framed_tag_matcher.sv -----
// Top level of the idle-framed tag matcher: config registers and the
// front, scan and back units. Uses itm_pkg, itm_front, itm_match, itm_back.
//
//   channel   handshake              payload
//   input     push / full            cmd    (in_item_t)
//   result    pop / empty            result (out_item_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Byte, load, unused and non-closing tick items are finished without a scan.
// A tick that closes a frame of 27 bytes or more scans the tag table one row
// per cycle, stopping at the first matching unused entry or after the last row.
// Reset clears all control state at once; tag and frame bytes are not cleared.
// Two-entry queues on the command and result sides let each side stall alone.
`timescale 1ns / 1ps

module idle_framed_tag_matcher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  itm_pkg::in_item_t  cmd,
	input  logic               pop,
	output logic               empty,
	output itm_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import itm_pkg::*;

	cfg_regs_t  cfg_q;
	logic       cmd_valid;
	cmd_t       cmd_head;
	logic       cmd_pop;
	logic       match_start;
	tag_row_t   window;
	tag_wr_t    tag_wr;
	match_rsp_t match_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_limit  <= 16'd8;
			cfg_q.led_hold    <= 16'd300;
			cfg_q.ignore_mask <= 17'd46128;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDLE_LIMIT:  cfg_q.idle_limit  <= cfg_data[15:0];
				CFG_LED_HOLD:    cfg_q.led_hold    <= cfg_data[15:0];
				CFG_IGNORE_MASK: cfg_q.ignore_mask <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	itm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (cmd),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head)
	);

	itm_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (match_start),
		.window (window),
		.tag_wr (tag_wr),
		.rsp    (match_rsp)
	);

	itm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd_head),
		.cmd_pop     (cmd_pop),
		.match_start (match_start),
		.window      (window),
		.tag_wr      (tag_wr),
		.match_rsp   (match_rsp),
		.pop         (pop),
		.empty       (empty),
		.result      (result)
	);

endmodule

// ----- src/itm_front.sv -----
// Front end: decodes incoming items into commands and holds them in a
// two-entry command queue for the back end. Uses itm_pkg.
`timescale 1ns / 1ps

module itm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  itm_pkg::in_item_t item,
	input  logic            cmd_pop,
	output logic            cmd_valid,
	output itm_pkg::cmd_t   cmd
);
	import itm_pkg::*;

	cmd_t       dec;
	logic       load_ok;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign load_ok = (32'(item.entry_index) < 32'(TAG_ENTRIES)) &&
	                 (32'(item.byte_index) < 32'(TAG_BYTES));

	always_comb begin
		dec.value = item.byte_value;
		dec.entry = ENTRY_W'(item.entry_index);
		dec.bsel  = BYTE_W'(item.byte_index);
		case (item.opcode)
			OP_BYTE: begin
				dec.kind = CMD_BYTE;
			end
			OP_TICK: begin
				dec.kind = CMD_TICK;
			end
			OP_LOAD: begin
				// out-of-range loads become no-ops here
				dec.kind = load_ok ? CMD_LOAD : CMD_NOP;
			end
			default: begin
				dec.kind = CMD_NOP;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/itm_match.sv -----
// Tag table memory, used marks and the entry scan unit.
// One row read per cycle, compare in the next cycle. Uses itm_pkg.
`timescale 1ns / 1ps

module itm_match (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  itm_pkg::tag_row_t   window,
	input  itm_pkg::tag_wr_t    tag_wr,
	output itm_pkg::match_rsp_t rsp
);
	import itm_pkg::*;

	localparam logic [ISSUE_W-1:0] ISSUE_END = ISSUE_W'(TAG_ENTRIES);
	localparam logic [ENTRY_W-1:0] LAST_IDX  = ENTRY_W'(TAG_ENTRIES - 1);

	tag_row_t                 tag_mem [TAG_ENTRIES];
	tag_row_t                 rd_q;
	logic [ENTRY_W-1:0]       cmp_idx_q;
	logic                     cmp_vld_q;
	logic                     busy_q;
	logic [ISSUE_W-1:0]       issue_q;
	logic [TAG_ENTRIES-1:0]   used_q;
	logic                     issuing;
	logic                     hit_now;
	logic                     last_now;

	assign issuing  = busy_q && (issue_q < ISSUE_END);
	assign hit_now  = busy_q && cmp_vld_q && !used_q[cmp_idx_q] && (rd_q == window);
	assign last_now = busy_q && cmp_vld_q && (cmp_idx_q == LAST_IDX);

	assign rsp.done = hit_now || last_now;
	assign rsp.hit  = hit_now;
	assign rsp.idx  = cmp_idx_q;

	always_ff @(posedge clk) begin
		if (tag_wr.en) begin
			tag_mem[tag_wr.entry][tag_wr.bsel] <= tag_wr.value;
		end
		if (issuing) begin
			rd_q      <= tag_mem[issue_q[ENTRY_W-1:0]];
			cmp_idx_q <= issue_q[ENTRY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issue_q   <= '0;
			cmp_vld_q <= 1'b0;
			used_q    <= '0;
		end else begin
			if (start) begin
				busy_q    <= 1'b1;
				issue_q   <= '0;
				cmp_vld_q <= 1'b0;
			end else if (rsp.done) begin
				busy_q    <= 1'b0;
				cmp_vld_q <= 1'b0;
				if (hit_now) begin
					used_q[cmp_idx_q] <= 1'b1;
				end
			end else if (busy_q) begin
				cmp_vld_q <= issuing;
				if (issuing) begin
					issue_q <= issue_q + ISSUE_W'(1);
				end
			end
		end
	end

endmodule

// ----- src/itm_back.sv -----
// Back end: frame length, tag window, idle and hold counters, result queue.
// Drives the scan unit in itm_match. Uses itm_pkg.
`timescale 1ns / 1ps

module itm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itm_pkg::cfg_regs_t   cfg,
	input  logic                 cmd_valid,
	input  itm_pkg::cmd_t        cmd,
	output logic                 cmd_pop,
	output logic                 match_start,
	output itm_pkg::tag_row_t    window,
	output itm_pkg::tag_wr_t     tag_wr,
	input  itm_pkg::match_rsp_t  match_rsp,
	input  logic                 pop,
	output logic                 empty,
	output itm_pkg::out_item_t   result
);
	import itm_pkg::*;

	back_state_t          state_q, state_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic signed [16:0]   idle_q, idle_d;
	logic [15:0]          hold_q, hold_d;
	tag_row_t             win_q;
	logic                 win_we;
	logic [BYTE_W-1:0]    win_idx;

	out_item_t            res_q [2];
	logic                 res_wr_q;
	logic                 res_rd_q;
	logic [1:0]           res_cnt_q;
	logic                 res_full;
	logic                 res_push;
	logic                 res_pop;
	out_item_t            res_d;

	logic signed [16:0]   idle_dec;
	logic                 closes;
	logic                 start_ok;
	logic                 is_reply;
	logic                 is_short;
	logic                 scan_go;
	logic [ID_W-1:0]      scan_id;

	function automatic logic [15:0] hold_step(input logic [15:0] base);
		return (base != 16'd0) ? base - 16'd1 : 16'd0;
	endfunction

	// a reported number at or above the mask width is never ignored
	function automatic logic is_ignored(input logic [ID_W-1:0] id,
	                                    input logic [MASK_W-1:0] mask);
		return (32'(id) < 32'(MASK_W)) && mask[5'(id)];
	endfunction

	assign window   = win_q;
	assign idle_dec = idle_q[16] ? idle_q : idle_q - 17'sd1;
	assign closes   = (idle_dec == 17'sd0);
	assign res_full = (res_cnt_q == 2'd2);
	assign start_ok = (state_q == BK_IDLE) && cmd_valid && !res_full;
	assign is_reply = (32'(len_q) == 32'(REPLY_LEN));
	assign is_short = (32'(len_q) < 32'(MATCH_MIN));
	assign scan_go  = start_ok && (cmd.kind == CMD_TICK) && closes && !is_reply && !is_short;
	assign scan_id  = match_rsp.hit ? ID_W'(match_rsp.idx) + ID_W'(1) : '0;
	assign win_idx  = BYTE_W'(len_q - LEN_W'(TAG_OFFSET));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (scan_go) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (match_rsp.done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res_d        = '0;
		match_start  = 1'b0;
		tag_wr.en    = 1'b0;
		tag_wr.entry = cmd.entry;
		tag_wr.bsel  = cmd.bsel;
		tag_wr.value = cmd.value;
		len_d        = len_q;
		idle_d       = idle_q;
		hold_d       = hold_q;
		win_we       = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (start_ok) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_BYTE: begin
							res_push = 1'b1;
							idle_d   = {1'b0, cfg.idle_limit};
							if (32'(len_q) < 32'(FRAME_MAX)) begin
								len_d  = len_q + LEN_W'(1);
								win_we = (32'(len_q) >= 32'(TAG_OFFSET)) && is_short;
							end else begin
								res_d.overflow = 1'b1;
							end
							res_d.led_on = (hold_q != 16'd0);
						end
						CMD_LOAD: begin
							res_push     = 1'b1;
							tag_wr.en    = 1'b1;
							res_d.led_on = (hold_q != 16'd0);
						end
						CMD_TICK: begin
							idle_d = idle_dec;
							if (!closes) begin
								res_push = 1'b1;
								hold_d   = hold_step(hold_q);
							end else begin
								len_d = '0;
								if (is_reply) begin
									res_push            = 1'b1;
									res_d.frame_done    = 1'b1;
									res_d.reply_request = 1'b1;
									hold_d              = hold_step(hold_q);
								end else if (is_short) begin
									res_push         = 1'b1;
									res_d.frame_done = 1'b1;
									hold_d = hold_step(is_ignored('0, cfg.ignore_mask) ?
									                   hold_q : cfg.led_hold);
								end else begin
									match_start = 1'b1;
								end
							end
							res_d.led_on = (hold_d != 16'd0);
						end
						default: begin
							res_push     = 1'b1;
							res_d.led_on = (hold_q != 16'd0);
						end
					endcase
				end
			end
			BK_SCAN: begin
				if (match_rsp.done) begin
					res_push         = 1'b1;
					res_d.frame_done = 1'b1;
					res_d.match_id   = 5'(scan_id);
					hold_d = hold_step(is_ignored(scan_id, cfg.ignore_mask) ?
					                   hold_q : cfg.led_hold);
					res_d.led_on = (hold_d != 16'd0);
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	assign empty   = (res_cnt_q == 2'd0);
	assign result  = res_q[res_rd_q];
	assign res_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_q[win_idx] <= cmd.value;
		end
		if (res_push) begin
			res_q[res_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			len_q     <= '0;
			idle_q    <= -17'sd1;
			hold_q    <= 16'd0;
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			idle_q  <= idle_d;
			hold_q  <= hold_d;
			if (res_push) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			case ({res_push, res_pop})
				2'b10: res_cnt_q <= res_cnt_q + 2'd1;
				2'b01: res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule
